// ===== rtl/vbt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbt_pkg
// Shared types, constants and tone tables of the vario beep tone sequencer.
// ----------------------------------------------------------------------------
package vbt_pkg;

    localparam int RATE_W      = 16;
    localparam int THRESH_W    = 11;
    localparam int CROSS_W     = 10;
    localparam int TONE_W      = 13;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int PHASE_W     = 6;
    localparam int ON_W        = 5;

    // interpolation datapath
    localparam int NUM_W         = 12;
    localparam int SPAN_W        = 15;
    localparam int DEN_W         = 12;
    localparam int PROD_W        = 27;
    localparam int DIV_DIVIDEND_W = 25;
    localparam int DIV_DIVISOR_W  = 11;
    localparam int DIV_COUNT_W    = $clog2(DIV_DIVIDEND_W);

    localparam logic signed [RATE_W-1:0] RATE_HI = 16'sd1000;
    localparam logic signed [RATE_W-1:0] RATE_LO = -16'sd1000;
    localparam logic [SPAN_W-1:0]        SINK_TONE_OFFSET = 15'd600;
    localparam logic [TONE_W-1:0]        SINK_STEP_HZ = 13'd20;

    localparam logic [PHASE_W-1:0] SINK_PERIOD   = 6'd40;
    localparam logic [ON_W-1:0]    SINK_ON       = 5'd30;
    localparam logic [PHASE_W-1:0] ZERO_PERIOD   = 6'd30;
    localparam logic [ON_W-1:0]    ZERO_ON       = 5'd2;
    localparam logic [PHASE_W-1:0] WARBLE_PERIOD = 6'd8;
    localparam logic [ON_W-1:0]    WARBLE_ON     = 5'd8;

    localparam logic [TONE_W-1:0] RST_MIN_TONE   = 13'd200;
    localparam logic [TONE_W-1:0] RST_MAX_TONE   = 13'd3200;
    localparam logic [TONE_W-1:0] RST_CROSS_TONE = 13'd1000;
    localparam logic [THRESH_W-1:0] RST_ZERO_TH  = 11'd5;
    localparam logic [THRESH_W-1:0] RST_SINK_TH  = 11'h706;
    localparam logic [THRESH_W-1:0] RST_CLIMB_TH = 11'd50;
    localparam logic [CROSS_W-1:0]  RST_CROSS_RATE = 10'd400;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ZERO_TH    = 3'd0,
        REG_SINK_TH    = 3'd1,
        REG_CLIMB_TH   = 3'd2,
        REG_CROSS_RATE = 3'd3,
        REG_MIN_TONE   = 3'd4,
        REG_MAX_TONE   = 3'd5,
        REG_CROSS_TONE = 3'd6
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                      start;
        logic [DIV_DIVIDEND_W-1:0] dividend;
        logic [DIV_DIVISOR_W-1:0]  divisor;
    } t_div_req;

    // rate / 100 for rates 0..999
    function automatic logic [3:0] climb_index(input logic [CROSS_W-1:0] rate);
        logic [3:0] idx;
        idx = 4'd0;
        for (int i = 1; i <= 9; i++) begin
            if (rate >= CROSS_W'(i * 100)) begin
                idx = 4'(idx + 4'd1);
            end
        end
        return idx;
    endfunction

    function automatic logic [PHASE_W-1:0] climb_period(input logic [3:0] idx);
        logic [PHASE_W-1:0] p;
        case (idx)
            4'd0:    p = 6'd16;
            4'd1:    p = 6'd14;
            4'd2:    p = 6'd12;
            4'd3:    p = 6'd10;
            4'd4:    p = 6'd9;
            4'd5:    p = 6'd8;
            4'd6:    p = 6'd7;
            4'd7:    p = 6'd6;
            4'd8:    p = 6'd5;
            default: p = 6'd4;
        endcase
        return p;
    endfunction

    function automatic logic [ON_W-1:0] climb_on(input logic [3:0] idx);
        logic [ON_W-1:0] o;
        case (idx)
            4'd0:    o = 5'd10;
            4'd1:    o = 5'd9;
            4'd2:    o = 5'd8;
            4'd3:    o = 5'd7;
            4'd4:    o = 5'd6;
            4'd5:    o = 5'd5;
            4'd6:    o = 5'd4;
            4'd7:    o = 5'd3;
            default: o = 5'd2;
        endcase
        return o;
    endfunction

    function automatic logic [TONE_W-1:0] warble_hi(input logic [2:0] k);
        logic [TONE_W-1:0] f;
        case (k)
            3'd0:    f = 13'd400;
            3'd1:    f = 13'd800;
            3'd2:    f = 13'd1200;
            3'd3:    f = 13'd1600;
            3'd4:    f = 13'd2000;
            3'd5:    f = 13'd1600;
            3'd6:    f = 13'd1200;
            default: f = 13'd800;
        endcase
        return f;
    endfunction

    function automatic logic [TONE_W-1:0] warble_lo(input logic [2:0] k);
        logic [TONE_W-1:0] f;
        case (k)
            3'd0:    f = 13'd4000;
            3'd1:    f = 13'd3500;
            3'd2:    f = 13'd3000;
            3'd3:    f = 13'd2500;
            3'd4:    f = 13'd2000;
            3'd5:    f = 13'd1500;
            3'd6:    f = 13'd1000;
            default: f = 13'd500;
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/vbt_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbt_divider
// Serial restoring divider for unsigned magnitudes, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module vbt_divider (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire vbt_pkg::t_div_req                  i_req,
    output logic                                    o_done,
    output logic [vbt_pkg::DIV_DIVIDEND_W-1:0]      o_quotient
);

    logic                                   r_busy;
    logic                                   r_done;
    logic [vbt_pkg::DIV_COUNT_W-1:0]        r_count;
    logic [vbt_pkg::DIV_DIVISOR_W-1:0]      r_rem;
    logic [vbt_pkg::DIV_DIVISOR_W-1:0]      r_divisor;
    logic [vbt_pkg::DIV_DIVIDEND_W-1:0]     r_quot;

    logic [vbt_pkg::DIV_DIVISOR_W:0]        w_shifted;
    logic [vbt_pkg::DIV_DIVISOR_W:0]        w_diff;
    logic                                   w_ge;

    always_comb begin
        w_shifted = {r_rem, r_quot[vbt_pkg::DIV_DIVIDEND_W-1]};
        w_diff    = w_shifted - {1'b0, r_divisor};
        w_ge      = (w_shifted >= {1'b0, r_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + 1'b1;
                if (r_count == vbt_pkg::DIV_COUNT_W'(vbt_pkg::DIV_DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= '0;
            r_quot    <= i_req.dividend;
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[vbt_pkg::DIV_DIVISOR_W-1:0]
                           : w_shifted[vbt_pkg::DIV_DIVISOR_W-1:0];
            r_quot <= {r_quot[vbt_pkg::DIV_DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule
`default_nettype wire

// ===== rtl/vario_beep_tone_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vario_beep_tone_sequencer
// Turns one climb rate per timer tick into the speaker tone for that tick.
// ----------------------------------------------------------------------------
// The input channel (i_in_valid / o_in_ready) takes one climb rate per tick;
// the output channel (o_out_valid / i_out_ready) gives exactly one item per
// input: the tone in Hz and a flag that is set when the tone was rewritten.
// The configuration port writes one register per cycle with i_cfg_we.
// The block handles one item at a time and is ready only when idle.
// A tick that continues a beep, or starts a warble or silence, passes through
// decode and output only. A tick that starts a beep with an interpolated tone
// passes through decode, multiply, divider start, the 25-step serial divider,
// add and clamp, and output. With a zero divisor the multiply and divide are
// skipped: decode, add and clamp, output.
// The result sits in an output register; the block accepts the next item
// while it waits, and only stalls before writing the following result.
// Reset clears the beep state and output valid and loads the register
// defaults; it needs no clearing pass.
// ----------------------------------------------------------------------------
module vario_beep_tone_sequencer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [vbt_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [vbt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [vbt_pkg::RATE_W-1:0]   i_climb_rate,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [vbt_pkg::TONE_W-1:0]               o_tone_hz,
    output logic                                     o_tone_update
);

    localparam int RW = vbt_pkg::RATE_W;
    localparam int TW = vbt_pkg::TONE_W;

    vbt_pkg::t_state r_state, n_state;

    // configuration
    logic [vbt_pkg::THRESH_W-1:0]  r_zero_th, r_sink_th, r_climb_th;
    logic [vbt_pkg::CROSS_W-1:0]   r_cross_rate;
    logic [TW-1:0]                 r_min_tone, r_max_tone, r_cross_tone;

    // beep state
    logic [vbt_pkg::PHASE_W-1:0]   r_phase, r_period;
    logic [vbt_pkg::ON_W-1:0]      r_on;
    logic signed [RW-1:0]          r_latched;
    logic [TW-1:0]                 r_tone;
    logic                          r_upd;
    logic                          r_out_valid, n_out_valid;

    // working registers
    logic signed [RW-1:0]              r_rate;
    logic signed [vbt_pkg::NUM_W-1:0]  r_num;
    logic signed [vbt_pkg::SPAN_W-1:0] r_span;
    logic signed [vbt_pkg::DEN_W-1:0]  r_den;
    logic [TW-1:0]                     r_base;
    logic                              r_use_q;
    logic                              r_q_neg;
    logic signed [vbt_pkg::PROD_W-1:0] r_prod;

    // decode of the latched item
    logic signed [RW-1:0]   w_zt, w_st, w_ct, w_cr;
    logic                   w_start;
    logic [vbt_pkg::PHASE_W-1:0] w_phase_n;
    logic [TW-1:0]          w_step_tone;
    logic                   w_is_sink, w_is_climb, w_is_zero, w_upper;
    logic                   w_warble_lo, w_warble_hi, w_interp;
    logic [3:0]             w_idx;
    logic [vbt_pkg::PHASE_W-1:0] w_new_period;
    logic [vbt_pkg::ON_W-1:0]    w_new_on;
    logic [TW-1:0]          w_new_tone;
    logic signed [RW:0]     w_rate_x, w_num_x;
    logic signed [vbt_pkg::SPAN_W-1:0] w_span;
    logic signed [vbt_pkg::DEN_W-1:0]  w_den;
    logic [TW-1:0]          w_base;

    logic signed [vbt_pkg::PROD_W-1:0] w_num_w, w_span_w, w_prod, w_prod_mag;
    logic signed [vbt_pkg::DEN_W-1:0]  w_den_mag;
    logic signed [vbt_pkg::PROD_W-1:0] w_q, w_f, w_min_w, w_max_w;
    logic [TW-1:0]                     w_clamped;
    logic                              w_slot_free;

    vbt_pkg::t_div_req                      w_div_req;
    logic                                   w_div_done;
    logic [vbt_pkg::DIV_DIVIDEND_W-1:0]     w_div_quot;

    assign o_in_ready = (r_state == vbt_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_slot_free = !r_out_valid || i_out_ready;

    // decision and next beep parameters
    always_comb begin
        w_zt = {{(RW - vbt_pkg::THRESH_W){r_zero_th[vbt_pkg::THRESH_W-1]}}, r_zero_th};
        w_st = {{(RW - vbt_pkg::THRESH_W){r_sink_th[vbt_pkg::THRESH_W-1]}}, r_sink_th};
        w_ct = {{(RW - vbt_pkg::THRESH_W){r_climb_th[vbt_pkg::THRESH_W-1]}}, r_climb_th};
        w_cr = {{(RW - vbt_pkg::CROSS_W){1'b0}}, r_cross_rate};

        w_start = (r_phase >= r_period) || ((r_rate >= w_ct) && (r_latched < w_ct));

        // continuing beep
        w_phase_n = r_phase + 1'b1;
        if (w_phase_n > {1'b0, r_on}) begin
            w_step_tone = '0;
        end else if (r_latched >= vbt_pkg::RATE_HI) begin
            w_step_tone = vbt_pkg::warble_hi(w_phase_n[2:0]);
        end else if (r_latched <= vbt_pkg::RATE_LO) begin
            w_step_tone = vbt_pkg::warble_lo(w_phase_n[2:0]);
        end else if (r_latched < w_st) begin
            w_step_tone = (r_tone > vbt_pkg::SINK_STEP_HZ) ? r_tone - vbt_pkg::SINK_STEP_HZ
                                                           : '0;
        end else begin
            w_step_tone = r_tone;
        end

        // new beep
        w_is_sink   = (r_rate <= w_st);
        w_warble_lo = (r_rate <= vbt_pkg::RATE_LO);
        w_is_climb  = (r_rate >= w_ct);
        w_warble_hi = (r_rate >= vbt_pkg::RATE_HI);
        w_is_zero   = (r_rate >= w_zt);
        w_upper     = (r_rate > w_cr);
        w_idx       = r_rate[RW-1] ? 4'd0 : vbt_pkg::climb_index(r_rate[vbt_pkg::CROSS_W-1:0]);
        w_rate_x    = {r_rate[RW-1], r_rate};

        w_interp = 1'b1;
        w_new_tone = '0;
        if (w_is_sink) begin
            w_interp     = !w_warble_lo;
            w_new_period = w_warble_lo ? vbt_pkg::WARBLE_PERIOD : vbt_pkg::SINK_PERIOD;
            w_new_on     = w_warble_lo ? vbt_pkg::WARBLE_ON : vbt_pkg::SINK_ON;
            w_new_tone   = vbt_pkg::warble_lo(3'd0);
        end else if (w_is_climb) begin
            w_interp     = !w_warble_hi;
            w_new_period = w_warble_hi ? vbt_pkg::WARBLE_PERIOD : vbt_pkg::climb_period(w_idx);
            w_new_on     = w_warble_hi ? vbt_pkg::WARBLE_ON : vbt_pkg::climb_on(w_idx);
            w_new_tone   = vbt_pkg::warble_hi(3'd0);
        end else if (w_is_zero) begin
            w_new_period = vbt_pkg::ZERO_PERIOD;
            w_new_on     = vbt_pkg::ZERO_ON;
        end else begin
            w_interp     = 1'b0;
            w_new_period = '0;
            w_new_on     = '0;
        end

        // interpolation operands
        if (w_is_sink) begin
            w_num_x = w_rate_x - {vbt_pkg::RATE_LO[RW-1], vbt_pkg::RATE_LO};
            w_span  = $signed({2'b00, r_min_tone}) + $signed(vbt_pkg::SINK_TONE_OFFSET)
                      - $signed({3'b000, r_max_tone[TW-1:1]});
            w_den   = $signed({w_st[vbt_pkg::DEN_W-1:0]})
                      - $signed(vbt_pkg::RATE_LO[vbt_pkg::DEN_W-1:0]);
            w_base  = {1'b0, r_max_tone[TW-1:1]};
        end else if (w_is_climb && w_upper) begin
            w_num_x = w_rate_x - {w_cr[RW-1], w_cr};
            w_span  = $signed({2'b00, r_max_tone}) - $signed({2'b00, r_cross_tone});
            w_den   = $signed(vbt_pkg::RATE_HI[vbt_pkg::DEN_W-1:0])
                      - $signed({2'b00, r_cross_rate});
            w_base  = r_cross_tone;
        end else begin
            w_num_x = w_rate_x - {w_zt[RW-1], w_zt};
            w_span  = $signed({2'b00, r_cross_tone}) - $signed({2'b00, r_min_tone});
            w_den   = $signed({2'b00, r_cross_rate}) - $signed(w_zt[vbt_pkg::DEN_W-1:0]);
            w_base  = r_min_tone;
        end
    end

    // multiply, magnitudes, add and clamp
    always_comb begin
        w_num_w  = {{(vbt_pkg::PROD_W - vbt_pkg::NUM_W){r_num[vbt_pkg::NUM_W-1]}}, r_num};
        w_span_w = {{(vbt_pkg::PROD_W - vbt_pkg::SPAN_W){r_span[vbt_pkg::SPAN_W-1]}}, r_span};
        w_prod   = w_num_w * w_span_w;
        w_prod_mag = r_prod[vbt_pkg::PROD_W-1] ? -r_prod : r_prod;
        w_den_mag  = r_den[vbt_pkg::DEN_W-1] ? -r_den : r_den;

        w_div_req.start    = (r_state == vbt_pkg::S_DSTART);
        w_div_req.dividend = w_prod_mag[vbt_pkg::DIV_DIVIDEND_W-1:0];
        w_div_req.divisor  = w_den_mag[vbt_pkg::DIV_DIVISOR_W-1:0];

        w_q = '0;
        if (r_use_q) begin
            w_q = $signed({{(vbt_pkg::PROD_W - vbt_pkg::DIV_DIVIDEND_W){1'b0}}, w_div_quot});
            if (r_q_neg) begin
                w_q = -w_q;
            end
        end
        w_f     = $signed({{(vbt_pkg::PROD_W - TW){1'b0}}, r_base}) + w_q;
        w_min_w = $signed({{(vbt_pkg::PROD_W - TW){1'b0}}, r_min_tone});
        w_max_w = $signed({{(vbt_pkg::PROD_W - TW){1'b0}}, r_max_tone});
        if (w_f < w_min_w) begin
            w_clamped = r_min_tone;
        end else if (w_f > w_max_w) begin
            w_clamped = r_max_tone;
        end else begin
            w_clamped = w_f[TW-1:0];
        end
    end

    vbt_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_div_quot)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vbt_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            vbt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = vbt_pkg::S_EVAL;
                end
            end
            vbt_pkg::S_EVAL: begin
                if (w_start && w_interp && (w_den != '0)) begin
                    n_state = vbt_pkg::S_MUL;
                end else if (w_start && w_interp) begin
                    n_state = vbt_pkg::S_FIN;
                end else begin
                    n_state = vbt_pkg::S_OUT;
                end
            end
            vbt_pkg::S_MUL:    n_state = vbt_pkg::S_DSTART;
            vbt_pkg::S_DSTART: n_state = vbt_pkg::S_DIV;
            vbt_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = vbt_pkg::S_FIN;
                end
            end
            vbt_pkg::S_FIN:    n_state = vbt_pkg::S_OUT;
            vbt_pkg::S_OUT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_state     = vbt_pkg::S_IDLE;
                end
            end
            default: n_state = vbt_pkg::S_IDLE;
        endcase
    end

    // configuration and beep state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_th    <= vbt_pkg::RST_ZERO_TH;
            r_sink_th    <= vbt_pkg::RST_SINK_TH;
            r_climb_th   <= vbt_pkg::RST_CLIMB_TH;
            r_cross_rate <= vbt_pkg::RST_CROSS_RATE;
            r_min_tone   <= vbt_pkg::RST_MIN_TONE;
            r_max_tone   <= vbt_pkg::RST_MAX_TONE;
            r_cross_tone <= vbt_pkg::RST_CROSS_TONE;
            r_phase      <= '0;
            r_period     <= '0;
            r_on         <= '0;
            r_latched    <= '0;
            r_tone       <= '0;
            r_upd        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (vbt_pkg::t_cfg_reg'(i_cfg_index))
                    vbt_pkg::REG_ZERO_TH:    r_zero_th    <= i_cfg_data[vbt_pkg::THRESH_W-1:0];
                    vbt_pkg::REG_SINK_TH:    r_sink_th    <= i_cfg_data[vbt_pkg::THRESH_W-1:0];
                    vbt_pkg::REG_CLIMB_TH:   r_climb_th   <= i_cfg_data[vbt_pkg::THRESH_W-1:0];
                    vbt_pkg::REG_CROSS_RATE: r_cross_rate <= i_cfg_data[vbt_pkg::CROSS_W-1:0];
                    vbt_pkg::REG_MIN_TONE:   r_min_tone   <= i_cfg_data[TW-1:0];
                    vbt_pkg::REG_MAX_TONE:   r_max_tone   <= i_cfg_data[TW-1:0];
                    vbt_pkg::REG_CROSS_TONE: r_cross_tone <= i_cfg_data[TW-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                vbt_pkg::S_EVAL: begin
                    if (w_start) begin
                        r_latched <= r_rate;
                        r_phase   <= '0;
                        r_period  <= w_new_period;
                        r_on      <= w_new_on;
                        r_upd     <= 1'b1;
                        if (!w_interp) begin
                            r_tone <= w_is_sink || w_is_climb ? w_new_tone : '0;
                        end
                    end else begin
                        r_phase <= w_phase_n;
                        r_tone  <= w_step_tone;
                        r_upd   <= (w_step_tone != r_tone);
                    end
                end
                vbt_pkg::S_FIN: r_tone <= w_clamped;
                default: ;
            endcase
        end
    end

    // item, interpolation operands and output registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            vbt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    r_rate <= i_climb_rate;
                end
            end
            vbt_pkg::S_EVAL: begin
                r_num   <= w_num_x[vbt_pkg::NUM_W-1:0];
                r_span  <= w_span;
                r_den   <= w_den;
                r_use_q <= (w_den != '0);
                r_base  <= (w_den != '0) ? w_base : r_max_tone;
            end
            vbt_pkg::S_MUL:    r_prod  <= w_prod;
            vbt_pkg::S_DSTART: r_q_neg <= r_prod[vbt_pkg::PROD_W-1] ^ r_den[vbt_pkg::DEN_W-1];
            vbt_pkg::S_OUT: begin
                if (w_slot_free) begin
                    o_tone_hz     <= r_tone;
                    o_tone_update <= r_upd;
                end
            end
            default: ;
        endcase
    end

    // checks
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == vbt_pkg::S_DIV))
        else $error("divider done outside wait state");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after an accepted item");

    a_period_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_period <= vbt_pkg::SINK_PERIOD) && (r_on <= vbt_pkg::SINK_ON))
        else $error("beep period or on-time out of range");

    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_out_valid) && $past(i_rst_n)) |-> $past(i_out_ready))
        else $error("result dropped without being taken");

endmodule
`default_nettype wire
